// ----- design/gtn_pkg.sv -----
// Package for the gesture trace normalizer: payload structs, controller states,
// controller/datapath command and status structs, and constants. No dependencies.
package gtn_pkg;

	localparam int MaxPointsDefault = 64;
	localparam logic [2:0] PassesReset = 3'd2;

	typedef struct packed {
		logic [7:0] point_x;
		logic [7:0] point_y;
		logic       last_point;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_x;
		logic [7:0] out_y;
		logic [5:0] out_index;
		logic [6:0] out_length;
		logic       out_last;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PICK,
		ST_DIV,
		ST_RS_RD,
		ST_RS_WR,
		ST_SM_RD,
		ST_SM_WR,
		ST_COPY,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic pick;
		logic div_start;
		logic rs_rd;
		logic rs_wr;
		logic sm_rd;
		logic sm_wr;
		logic copy;
		logic emit;
		logic idx_clr;
		logic idx_inc;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic last_idx;
		logic do_resample;
		logic do_smooth;
		logic pass_last;
		logic empty;
	} stat_t;

	function automatic logic [6:0] pick_length(input logic [6:0] len, input logic [6:0] cap);
		logic [6:0] best;
		begin
			if (len <= 7'd1)
				best = len;
			else if (len <= 7'd20)
				best = 7'd16;
			else if (len <= 7'd28)
				best = 7'd24;
			else if (len <= 7'd40)
				best = 7'd32;
			else if (len <= 7'd56)
				best = 7'd48;
			else if (len <= 7'd80)
				best = 7'd64;
			else
				best = 7'd96;
			if (len > 7'd1 && best > cap)
				best = cap;
			return best;
		end
	endfunction

endpackage

// ----- design/gesture_trace_normalizer.sv -----
// Top level of the gesture trace normalizer: configuration register and the
// controller and datapath instances. Depends on gtn_pkg, gtn_ctrl and gtn_datapath.
//
//  channel   handshake            payload
//  input     start / busy         point  (in_word_t)
//  config    cfg_valid/cfg_ready  cfg_data (3 bits)
//  result    result_valid strobe  result (out_word_t)
//
// Each point is loaded while start is high and busy is low. After the last point the
// block is busy: it picks the length, resamples each point (a 20-step serial divider,
// a done flag, a read and a write), reads and writes each point for each smoothing
// pass, copies the work store back after resampling and after each pass, then emits.
// Reset clears the counters and sets the pass count to two. Results cannot be stalled.
module gesture_trace_normalizer import gtn_pkg::*; #(
	parameter int MAX_POINTS = MaxPointsDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_word_t   point,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_data,
	output logic       result_valid,
	output out_word_t  result
);

	logic [2:0] passes_q;
	cmd_t cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			passes_q <= PassesReset;
		else if (cfg_valid)
			passes_q <= cfg_data;
	end

	gtn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .last_point(point.last_point),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	gtn_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .point(point),
		.passes_cfg(passes_q), .result_valid(result_valid), .result(result)
	);

endmodule

// ----- design/gtn_ctrl.sv -----
// Controller state machine for the gesture trace normalizer.
// Depends on gtn_pkg for the state, command and status types.
module gtn_ctrl import gtn_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  logic   last_point,
	input  stat_t  stat,
	output cmd_t   cmd,
	output logic   busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_LOAD: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (last_point)
						state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				cmd.idx_clr = 1'b1;
				if (stat.empty)
					state_d = ST_LOAD;
				else if (stat.do_resample) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else if (stat.do_smooth)
					state_d = ST_SM_RD;
				else
					state_d = ST_EMIT;
			end
			ST_DIV: begin
				if (stat.div_done)
					state_d = ST_RS_RD;
			end
			ST_RS_RD: begin
				cmd.rs_rd = 1'b1;
				state_d = ST_RS_WR;
			end
			ST_RS_WR: begin
				cmd.rs_wr = 1'b1;
				if (stat.last_idx) begin
					cmd.idx_clr = 1'b1;
					state_d = ST_COPY;
				end else begin
					cmd.idx_inc = 1'b1;
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_SM_RD: begin
				cmd.sm_rd = 1'b1;
				state_d = ST_SM_WR;
			end
			ST_SM_WR: begin
				cmd.sm_wr = 1'b1;
				if (stat.last_idx) begin
					cmd.idx_clr = 1'b1;
					state_d = ST_COPY;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = ST_SM_RD;
				end
			end
			ST_COPY: begin
				cmd.copy = 1'b1;
				if (stat.last_idx) begin
					cmd.idx_clr = 1'b1;
					state_d = stat.pass_last ? ST_EMIT : ST_SM_RD;
				end else
					cmd.idx_inc = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				cmd.idx_inc = 1'b1;
				if (stat.last_idx)
					state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

endmodule

// ----- design/gtn_datapath.sv -----
// Datapath of the gesture trace normalizer: trace and work stores, serial divider,
// interpolation and smoothing arithmetic, and the result register. Depends on gtn_pkg.
module gtn_datapath import gtn_pkg::*; #(
	parameter int MAX_POINTS = MaxPointsDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	output stat_t     stat,
	input  in_word_t  point,
	input  logic [2:0] passes_cfg,
	output logic      result_valid,
	output out_word_t result
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam logic [6:0] Cap = 7'(MAX_POINTS);

	logic [15:0] trace_mem [MAX_POINTS];
	logic [15:0] work_mem [MAX_POINTS];

	logic [6:0]  count_q;
	logic [6:0]  old_len_q, new_len_q;
	logic [6:0]  idx_q;
	logic [2:0]  pass_q;
	logic        rs_q;

	// Serial divider: quotient = idx*(old-1)*256 / (new-1), 20-bit dividend.
	logic [19:0] dvd_q;
	logic [14:0] quo_q;
	logic [6:0]  rem_q;
	logic [6:0]  dvs_q;
	logic [4:0]  dcnt_q;
	logic        dbusy_q;
	logic        ddone_q;

	logic [15:0] ta_q, tb_q, tc_q;
	logic [7:0]  frac_q;
	logic [15:0] wr_data;
	logic [7:0]  rs_x, rs_y, sm_x, sm_y;
	logic [6:0]  picked;
	logic [7:0]  trial;

	assign picked = pick_length(count_q, Cap);
	assign trial = {rem_q, dvd_q[19]};

	function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] f);
		logic [15:0] p;
		begin
			if (b >= a) begin
				p = 16'(b - a) * 16'(f);
				return a + p[15:8];
			end else begin
				p = 16'(a - b) * 16'(f) + 16'd255;
				return a - p[15:8];
			end
		end
	endfunction

	function automatic logic [7:0] tap3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [9:0] s;
		begin
			s = 10'(a) + {1'b0, b, 1'b0} + 10'(c);
			return s[9:2];
		end
	endfunction

	assign rs_x = lerp(ta_q[15:8], tb_q[15:8], frac_q);
	assign rs_y = lerp(ta_q[7:0], tb_q[7:0], frac_q);
	assign sm_x = tap3(ta_q[15:8], tb_q[15:8], tc_q[15:8]);
	assign sm_y = tap3(ta_q[7:0], tb_q[7:0], tc_q[7:0]);

	always_comb begin
		if (cmd.rs_wr)
			wr_data = {rs_x, rs_y};
		else if (idx_q == 7'd0 || idx_q == new_len_q - 7'd1)
			wr_data = tb_q;
		else
			wr_data = {sm_x, sm_y};
	end

	assign stat.div_done = ddone_q;
	assign stat.empty = (count_q == 7'd0);
	assign stat.do_resample = (picked != count_q) && (count_q > 7'd1);
	assign stat.do_smooth = (picked >= 7'd3) && (passes_cfg != 3'd0);
	assign stat.pass_last = rs_q ? (pass_q == 3'd0) : (pass_q == 3'd1);
	assign stat.last_idx = (idx_q == new_len_q - 7'd1);

	// Stores: one write port and registered reads; smoothing slides a three-point window.
	always_ff @(posedge clk) begin
		if (cmd.load && count_q < Cap)
			trace_mem[count_q[AW-1:0]] <= {point.point_x, point.point_y};
		if (cmd.rs_rd) begin
			ta_q <= trace_mem[quo_q[14:8] > old_len_q - 7'd1 ?
				AW'(old_len_q - 7'd1) : AW'(quo_q[14:8])];
			tb_q <= trace_mem[quo_q[14:8] + 7'd1 > old_len_q - 7'd1 ?
				AW'(old_len_q - 7'd1) : AW'(quo_q[14:8] + 7'd1)];
			frac_q <= quo_q[7:0];
		end
		if (cmd.sm_rd) begin
			if (idx_q == 7'd0) begin
				tb_q <= trace_mem[AW'(idx_q)];
				tc_q <= trace_mem[AW'(idx_q + 7'd1)];
			end else begin
				ta_q <= tb_q;
				tb_q <= tc_q;
				tc_q <= trace_mem[AW'(stat.last_idx ? idx_q : idx_q + 7'd1)];
			end
		end
		if (cmd.rs_wr || cmd.sm_wr)
			work_mem[AW'(idx_q)] <= wr_data;
		if (cmd.copy)
			trace_mem[AW'(idx_q)] <= work_mem[AW'(idx_q)];
		if (cmd.emit) begin
			result.out_x <= trace_mem[AW'(idx_q)][15:8];
			result.out_y <= trace_mem[AW'(idx_q)][7:0];
			result.out_index <= idx_q[5:0];
			result.out_length <= new_len_q;
			result.out_last <= stat.last_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			old_len_q <= '0;
			new_len_q <= 7'd1;
			idx_q <= '0;
			pass_q <= '0;
			rs_q <= 1'b0;
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q <= '0;
			dvd_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			dvs_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
			ddone_q <= dbusy_q && !cmd.div_start && (dcnt_q == 5'd1);
			if (cmd.load && count_q < Cap)
				count_q <= count_q + 7'd1;
			if (cmd.pick) begin
				count_q <= '0;
				old_len_q <= count_q;
				rs_q <= stat.do_resample;
				new_len_q <= stat.do_resample ? picked : count_q;
				pass_q <= passes_cfg;
			end
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + 7'd1;
			if (cmd.copy && stat.last_idx) begin
				if (rs_q)
					rs_q <= 1'b0;
				else
					pass_q <= pass_q - 3'd1;
			end
			if (cmd.div_start) begin
				logic [6:0] i;
				logic [6:0] m;
				logic [13:0] prod;
				i = cmd.pick ? 7'd0 : idx_q + 7'd1;
				m = (cmd.pick ? count_q : old_len_q) - 7'd1;
				prod = 14'(i) * 14'(m);
				dvd_q <= {prod[11:0], 8'd0};
				dvs_q <= (cmd.pick ? picked : new_len_q) - 7'd1;
				rem_q <= '0;
				dcnt_q <= 5'd20;
				dbusy_q <= 1'b1;
			end else if (dbusy_q) begin
				if (trial >= {1'b0, dvs_q}) begin
					rem_q <= 7'(trial - {1'b0, dvs_q});
					quo_q <= {quo_q[13:0], 1'b1};
				end else begin
					rem_q <= trial[6:0];
					quo_q <= {quo_q[13:0], 1'b0};
				end
				dvd_q <= {dvd_q[18:0], 1'b0};
				dcnt_q <= dcnt_q - 5'd1;
				if (dcnt_q == 5'd1)
					dbusy_q <= 1'b0;
			end
		end
	end

endmodule
